// File: hw/rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types, constants and helpers for the Art-Net packet classifier.
// ----------------------------------------------------------------------------
package apc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_POLL_REPLY_ENABLE = 2'd0;
  localparam logic [1:0] REG_DMX_MIN_BYTES     = 2'd1;
  localparam logic [1:0] REG_POLL_MIN_BYTES    = 2'd2;

  localparam int CFG_W = 11;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] DMX_MIN_RESET  = 11'd530;
  localparam logic [CFG_W-1:0] POLL_MIN_RESET = 11'd14;

  // Opcodes
  localparam logic [15:0] OPC_DMX  = 16'h5000;
  localparam logic [15:0] OPC_POLL = 16'h2000;

  // Header byte offsets
  localparam int SIG_BYTES   = 8;
  localparam int POS_OPC_LO  = 8;
  localparam int POS_OPC_HI  = 9;
  localparam int MIN_HEADER  = 12;
  localparam int POS_SEQ     = 12;
  localparam int POS_UNI_LO  = 14;
  localparam int POS_UNI_HI  = 15;
  localparam int POS_LEN_HI  = 16;
  localparam int POS_LEN_LO  = 17;

  // Legal DMX channel count
  localparam logic [15:0] CHAN_MIN = 16'd2;
  localparam logic [15:0] CHAN_MAX = 16'd512;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int Q_AW   = 2;

  localparam int OUT_TDATA_W = 208;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_DMX     = 2'd1,
    ST_POLL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // One summary, packed with packet_status in the lowest bits
  typedef struct packed {
    logic [31:0] jump_total;
    logic [31:0] poll_total;
    logic [31:0] dmx_total;
    logic [31:0] invalid_total;
    logic [31:0] total_packets;
    logic        reply_request;
    logic        sequence_jump;
    logic [7:0]  sequence_number;
    logic [15:0] channel_count;
    logic [15:0] universe;
    status_t     packet_status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // "Art-Net" followed by a zero byte
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h41;
      3'd1: b = 8'h72;
      3'd2: b = 8'h74;
      3'd3: b = 8'h2D;
      3'd4: b = 8'h4E;
      3'd5: b = 8'h65;
      3'd6: b = 8'h74;
      3'd7: b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Saturating counter step
  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
    logic [31:0] r;
    r = v;
    if (en && (v != 32'hFFFF_FFFF)) begin
      r = v + 32'd1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/artnet_packet_classifier_core.sv
// ----------------------------------------------------------------------------
// artnet_packet_classifier_core
// Art-Net datagram classifier: header capture, per-universe sequence check
// and saturating statistics, one summary per datagram.
// ----------------------------------------------------------------------------
// Throughput: one payload byte per clock, also across datagrams, as long as
//   the output queue has room; m_tready back-pressure can hold s_tready low.
// Summary path: held in stage 1 for the table read, then updated and queued.
// Reset: synchronous rst clears control, counters and capture state, then a
//   clearing pass over every table entry zeroes the sequence table; no byte
//   is accepted during that pass. Configuration writes are taken when rst is low.
// ----------------------------------------------------------------------------
module artnet_packet_classifier_core #(
  parameter int UNIVERSE_SLOTS   = 16,
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [apc_pkg::CFG_W-1:0]     cfg_data,
  // byte stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic                          s_tlast,   // last_byte
  // summary stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] packet_status, [17:2] universe, [33:18] channel_count,
  // [41:34] sequence_number, [42] sequence_jump, [43] reply_request,
  // [75:44] total_packets, [107:76] invalid_total, [139:108] dmx_total,
  // [171:140] poll_total, [203:172] jump_total, [207:204] zero
  output logic [apc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import apc_pkg::*;

  localparam int AW    = (UNIVERSE_SLOTS > 1) ? $clog2(UNIVERSE_SLOTS) : 1;
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CMP_W = (POS_W > CFG_W) ? POS_W : CFG_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic             poll_reply_enable;
  logic [CFG_W-1:0] dmx_min_bytes;
  logic [CFG_W-1:0] poll_min_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_reply_enable <= 1'b1;
      dmx_min_bytes     <= DMX_MIN_RESET;
      poll_min_bytes    <= POLL_MIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_POLL_REPLY_ENABLE: poll_reply_enable <= cfg_data[0];
        REG_DMX_MIN_BYTES:     dmx_min_bytes     <= cfg_data;
        REG_POLL_MIN_BYTES:    poll_min_bytes    <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Header capture: one byte per request, positions past the size limit are
  // ignored so the length saturates at MAX_PACKET_BYTES.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] pos, pos_next;
  logic             sig_ok, sig_ok_next;
  logic [15:0]      opcode, opcode_next;
  logic [7:0]       seq, seq_next;
  logic [15:0]      uni, uni_next;
  logic [15:0]      len, len_next;

  logic in_fire;
  assign in_fire = s_tvalid && s_tready;

  always_comb begin
    pos_next    = pos;
    sig_ok_next = sig_ok;
    opcode_next = opcode;
    seq_next    = seq;
    uni_next    = uni;
    len_next    = len;
    if (pos < POS_W'(MAX_PACKET_BYTES)) begin
      if (pos < POS_W'(SIG_BYTES)) begin
        if (s_tdata != sig_byte(pos[2:0])) begin
          sig_ok_next = 1'b0;
        end
      end else if (pos == POS_W'(POS_OPC_LO)) begin
        opcode_next[7:0] = s_tdata;
      end else if (pos == POS_W'(POS_OPC_HI)) begin
        opcode_next[15:8] = s_tdata;
      end else if (pos == POS_W'(POS_SEQ)) begin
        seq_next = s_tdata;
      end else if (pos == POS_W'(POS_UNI_LO)) begin
        uni_next[7:0] = s_tdata;
      end else if (pos == POS_W'(POS_UNI_HI)) begin
        uni_next[15:8] = s_tdata;
      end else if (pos == POS_W'(POS_LEN_HI)) begin
        len_next[15:8] = s_tdata;
      end else if (pos == POS_W'(POS_LEN_LO)) begin
        len_next[7:0] = s_tdata;
      end
      pos_next = pos + POS_W'(1);
    end
  end

  // Classification of the datagram as it stands after the current byte
  status_t     cls_status;
  logic        cls_dmx_proc;
  logic        cls_poll_proc;
  logic        cls_chk;
  logic        cls_reply;
  logic [15:0] cls_uni;
  logic [15:0] cls_cnt;
  logic [7:0]  cls_seq;
  logic        in_table;
  logic [CMP_W-1:0] pos_ext;

  assign pos_ext  = CMP_W'(pos_next);
  assign in_table = ({1'b0, uni_next} < 17'(UNIVERSE_SLOTS));

  always_comb begin
    cls_status    = ST_IGNORED;
    cls_dmx_proc  = 1'b0;
    cls_poll_proc = 1'b0;
    cls_chk       = 1'b0;
    cls_reply     = 1'b0;
    cls_uni       = '0;
    cls_cnt       = '0;
    cls_seq       = '0;
    if ((pos_next < POS_W'(MIN_HEADER)) || !sig_ok_next) begin
      cls_status = ST_INVALID;
    end else if (opcode_next == OPC_DMX) begin
      if (pos_ext >= CMP_W'(dmx_min_bytes)) begin
        cls_dmx_proc = 1'b1;
        cls_uni      = uni_next;
        cls_cnt      = len_next;
        cls_seq      = seq_next;
        if ((len_next < CHAN_MIN) || (len_next > CHAN_MAX)) begin
          cls_status = ST_INVALID;
        end else begin
          cls_status = ST_DMX;
          cls_chk    = in_table;
        end
      end
    end else if (opcode_next == OPC_POLL) begin
      if (pos_ext >= CMP_W'(poll_min_bytes)) begin
        cls_poll_proc = 1'b1;
        cls_status    = ST_POLL;
        cls_reply     = poll_reply_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      sig_ok <= 1'b1;
      opcode <= '0;
      seq    <= '0;
      uni    <= '0;
      len    <= '0;
    end else if (in_fire) begin
      if (s_tlast) begin
        // return to the start-of-datagram state
        pos    <= '0;
        sig_ok <= 1'b1;
        opcode <= '0;
        seq    <= '0;
        uni    <= '0;
        len    <= '0;
      end else begin
        pos    <= pos_next;
        sig_ok <= sig_ok_next;
        opcode <= opcode_next;
        seq    <= seq_next;
        uni    <= uni_next;
        len    <= len_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: summary waits here while the table entry is read
  // --------------------------------------------------------------------------
  logic          s1_valid;
  status_t       s1_status;
  logic          s1_dmx_proc;
  logic          s1_poll_proc;
  logic          s1_chk;
  logic          s1_reply;
  logic [15:0]   s1_uni;
  logic [15:0]   s1_cnt;
  logic [7:0]    s1_seq;
  logic          s1_fwd;
  logic [7:0]    s1_fwd_data;

  logic          summ_fire;
  assign summ_fire = in_fire && s_tlast;

  // Table RAM
  logic          clr_busy;
  logic [AW-1:0] clr_idx;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          upd_we;

  assign ram_raddr = uni_next[AW-1:0];
  assign upd_we    = s1_valid && s1_chk;

  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s1_uni[AW-1:0];
      ram_wdata = s1_seq;
    end
  end

  apc_ram #(
    .WIDTH (8),
    .DEPTH (UNIVERSE_SLOTS)
  ) u_seq_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= summ_fire;
    end
    if (summ_fire) begin
      s1_status    <= cls_status;
      s1_dmx_proc  <= cls_dmx_proc;
      s1_poll_proc <= cls_poll_proc;
      s1_chk       <= cls_chk;
      s1_reply     <= cls_reply;
      s1_uni       <= cls_uni;
      s1_cnt       <= cls_cnt;
      s1_seq       <= cls_seq;
      // the write of the previous summary lands at this edge; the read
      // returns old data, so forward the value being written
      s1_fwd       <= upd_we && (s1_uni[AW-1:0] == ram_raddr);
      s1_fwd_data  <= s1_seq;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      if (clr_idx == AW'(UNIVERSE_SLOTS - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sequence check, table write-back, statistics, queue the summary
  // --------------------------------------------------------------------------
  logic [7:0]  prev_seq;
  logic        s2_jump;
  logic [31:0] cnt_total, cnt_invalid, cnt_dmx, cnt_poll, cnt_jump;
  logic [31:0] cnt_total_next, cnt_invalid_next, cnt_dmx_next, cnt_poll_next;
  logic [31:0] cnt_jump_next;
  result_t     res;

  assign prev_seq = s1_fwd ? s1_fwd_data : ram_rdata;
  assign s2_jump  = s1_chk && (prev_seq != 8'd0) && (s1_seq != (prev_seq + 8'd1));

  assign cnt_total_next   = sat_inc(cnt_total, 1'b1);
  assign cnt_invalid_next = sat_inc(cnt_invalid, s1_status == ST_INVALID);
  assign cnt_dmx_next     = sat_inc(cnt_dmx, s1_dmx_proc);
  assign cnt_poll_next    = sat_inc(cnt_poll, s1_poll_proc);
  assign cnt_jump_next    = sat_inc(cnt_jump, s2_jump);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_total   <= '0;
      cnt_invalid <= '0;
      cnt_dmx     <= '0;
      cnt_poll    <= '0;
      cnt_jump    <= '0;
    end else if (s1_valid) begin
      cnt_total   <= cnt_total_next;
      cnt_invalid <= cnt_invalid_next;
      cnt_dmx     <= cnt_dmx_next;
      cnt_poll    <= cnt_poll_next;
      cnt_jump    <= cnt_jump_next;
    end
  end

  always_comb begin
    res.packet_status   = s1_status;
    res.universe        = s1_uni;
    res.channel_count   = s1_cnt;
    res.sequence_number = s1_seq;
    res.sequence_jump   = s2_jump;
    res.reply_request   = s1_reply;
    res.total_packets   = cnt_total_next;
    res.invalid_total   = cnt_invalid_next;
    res.dmx_total       = cnt_dmx_next;
    res.poll_total      = cnt_poll_next;
    res.jump_total      = cnt_jump_next;
  end

  // --------------------------------------------------------------------------
  // Output queue. Stage 2 never stalls, so hold input until the queue has a
  // slot for everything already in flight plus one more summary.
  // --------------------------------------------------------------------------
  result_t       q_mem [QDEPTH];
  logic [Q_AW-1:0] q_wr, q_rd;
  logic [Q_AW:0]   q_count;
  logic            q_pop;

  assign m_tvalid = (q_count != '0);
  assign q_pop    = m_tvalid && m_tready;
  assign m_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), q_mem[q_rd]};
  assign s_tready = !clr_busy && ((q_count + (Q_AW+1)'(s1_valid)) < (Q_AW+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        q_wr <= q_wr + Q_AW'(1);
      end
      if (q_pop) begin
        q_rd <= q_rd + Q_AW'(1);
      end
      q_count <= q_count + (Q_AW+1)'(s1_valid) - (Q_AW+1)'(q_pop);
    end
    if (s1_valid) begin
      q_mem[q_wr] <= res;
    end
  end

endmodule

// File: hw/rtl/apc_ram.sv
// ----------------------------------------------------------------------------
// apc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module apc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
